// ----- rtl/abhd_pkg.sv -----
package abhd_pkg;

    // one prediction cell of the detection head
    typedef struct packed {
        logic        [1:0]  level;
        logic        [1:0]  anchor_slot;
        logic        [6:0]  grid_col;
        logic        [6:0]  grid_row;
        logic signed [15:0] logit_x;
        logic signed [15:0] logit_y;
        logic signed [15:0] logit_w;
        logic signed [15:0] logit_h;
        logic signed [15:0] logit_obj;
        logic signed [15:0] logit_cls;
    } cell_t;

    // one decoded box
    typedef struct packed {
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic        [14:0] box_width;
        logic        [14:0] box_height;
        logic        [15:0] score;
    } box_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SCORE_THRESHOLD = 3'd0,
        REG_PAD_LEFT        = 3'd1,
        REG_PAD_TOP         = 3'd2,
        REG_SCALE_X         = 3'd3,
        REG_SCALE_Y         = 3'd4
    } cfg_reg_t;

    localparam logic [15:0] SCORE_THRESHOLD_RESET = 16'd45875;
    localparam logic [8:0]  PAD_RESET             = 9'd0;
    localparam logic [15:0] SCALE_RESET           = 16'd256;
    localparam logic [15:0] SIG_MAX               = 16'hFFFF;

    // sigmoid(k/2) in Q0.16 for k = 0..16
    function automatic logic [15:0] sig_entry(input logic [4:0] k);
        logic [15:0] v;
        case (k)
            5'd0:    v = 16'd32768;
            5'd1:    v = 16'd40793;
            5'd2:    v = 16'd47911;
            5'd3:    v = 16'd53581;
            5'd4:    v = 16'd57724;
            5'd5:    v = 16'd60565;
            5'd6:    v = 16'd62428;
            5'd7:    v = 16'd63615;
            5'd8:    v = 16'd64357;
            5'd9:    v = 16'd64816;
            5'd10:   v = 16'd65097;
            5'd11:   v = 16'd65269;
            5'd12:   v = 16'd65374;
            5'd13:   v = 16'd65438;
            5'd14:   v = 16'd65476;
            5'd15:   v = 16'd65500;
            5'd16:   v = 16'd65514;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Q8.8 logit to Q0.16 probability, table with linear interpolation
    function automatic logic [15:0] sigmoid_q16(input logic [15:0] x);
        logic [15:0] a;
        logic [3:0]  i;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [12:0] d;
        logic [19:0] prod;
        logic [15:0] p;
        a    = x[15] ? 16'(~x + 16'd1) : x;
        i    = a[10:7];
        lo   = sig_entry({1'b0, i});
        hi   = sig_entry({1'b0, i} + 5'd1);
        d    = 13'(hi - lo);
        prod = d * a[6:0];
        if (a[15:11] != 5'd0)
            p = SIG_MAX;
        else
            p = lo + 16'(prod[19:7]);
        return x[15] ? 16'(17'h10000 - {1'b0, p}) : p;
    endfunction

    // anchor size in network pixels; vert selects height over width
    function automatic logic [8:0] anchor_size(input logic [1:0] level,
                                               input logic [1:0] slot,
                                               input logic       vert);
        logic [8:0] v;
        case ({level, slot, vert})
            {2'd0, 2'd0, 1'b0}: v = 9'd10;
            {2'd0, 2'd0, 1'b1}: v = 9'd13;
            {2'd0, 2'd1, 1'b0}: v = 9'd16;
            {2'd0, 2'd1, 1'b1}: v = 9'd30;
            {2'd0, 2'd2, 1'b0}: v = 9'd33;
            {2'd0, 2'd2, 1'b1}: v = 9'd23;
            {2'd1, 2'd0, 1'b0}: v = 9'd30;
            {2'd1, 2'd0, 1'b1}: v = 9'd61;
            {2'd1, 2'd1, 1'b0}: v = 9'd62;
            {2'd1, 2'd1, 1'b1}: v = 9'd45;
            {2'd1, 2'd2, 1'b0}: v = 9'd59;
            {2'd1, 2'd2, 1'b1}: v = 9'd119;
            {2'd2, 2'd0, 1'b0}: v = 9'd116;
            {2'd2, 2'd0, 1'b1}: v = 9'd90;
            {2'd2, 2'd1, 1'b0}: v = 9'd156;
            {2'd2, 2'd1, 1'b1}: v = 9'd198;
            {2'd2, 2'd2, 1'b0}: v = 9'd373;
            {2'd2, 2'd2, 1'b1}: v = 9'd326;
            default:            v = 9'd0;
        endcase
        return v;
    endfunction

    // center in Q.16 network pixels, shifted by the level stride, minus padding
    function automatic logic signed [30:0] center_q16(input logic [15:0] s,
                                                      input logic [6:0]  cell_idx,
                                                      input logic [1:0]  level,
                                                      input logic [8:0]  pad);
        logic signed [25:0] base;
        logic signed [30:0] scaled;
        base = $signed({9'b0, s, 1'b0}) - 26'sd32768 + $signed({3'b0, cell_idx, 16'b0});
        case (level)
            2'd0:    scaled = 31'(base) <<< 3;
            2'd1:    scaled = 31'(base) <<< 4;
            2'd2:    scaled = 31'(base) <<< 5;
            default: scaled = 31'sd0;
        endcase
        return scaled - $signed({6'b0, pad, 16'b0});
    endfunction

    // trunc toward zero of num / 2^25, saturated to 16 bits signed
    function automatic logic signed [15:0] edge_px(input logic signed [49:0] num);
        logic signed [49:0] adj;
        logic        [24:0] q;
        logic signed [15:0] r;
        adj = num + (num[49] ? 50'sd33554431 : 50'sd0);
        q   = adj[49:25];
        if (q[24:15] == 10'h000 || q[24:15] == 10'h3FF)
            r = $signed(q[15:0]);
        else
            r = q[24] ? 16'sh8000 : 16'sh7FFF;
        return r;
    endfunction

    // w24 >> 24, saturated to 15 bits
    function automatic logic [14:0] extent_px(input logic [42:0] w24);
        return (w24[42:39] != 4'd0) ? 15'h7FFF : w24[38:24];
    endfunction

endpackage

// ----- rtl/anchor_box_head_decode.sv -----
// Anchor-box detection head decoder. Takes one prediction cell per cycle on the
// cell channel while cell_ready is high, and gives zero or one decoded box for
// it on the box channel. The cell passes through a six-stage pipeline: table
// sigmoids, then the score product, size squares and centers, then the anchor
// and scale multiplies, then the edge numerators, extents, truncation and
// saturation. Cells whose level or anchor slot is three, or that fail the score
// threshold, are dropped inside the pipeline and leave a bubble, never a box.
// A stall on the box side backs up stage by stage, so bubbles are squeezed out
// and the cell side keeps taking cells while any stage is free. Configuration
// writes are always taken and act at once; write them only with the pipeline
// empty.
module anchor_box_head_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cell_valid,
    output logic                cell_ready,
    input  abhd_pkg::cell_t     cell_data,
    output logic                box_valid,
    input  logic                box_ready,
    output abhd_pkg::box_t      box,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    // configuration registers
    logic [15:0] score_threshold_reg;
    logic [8:0]  pad_left_reg;
    logic [8:0]  pad_top_reg;
    logic [15:0] scale_x_reg;
    logic [15:0] scale_y_reg;

    // stage valid bits and per-stage ready chain
    logic [6:1] v_reg;
    logic [6:1] v_next;
    logic [6:1] rdy;

    // stage 1: probabilities
    logic [1:0]  level1_reg;
    logic [1:0]  slot1_reg;
    logic [6:0]  col1_reg;
    logic [6:0]  row1_reg;
    logic [15:0] sx1_reg;
    logic [15:0] sy1_reg;
    logic [15:0] sw1_reg;
    logic [15:0] sh1_reg;
    logic [15:0] sobj1_reg;
    logic [15:0] scls1_reg;

    // stage 2: score, squares, centers
    logic [15:0]        score2_reg;
    logic               obj_ok2_reg;
    logic [31:0]        sqw2_reg;
    logic [31:0]        sqh2_reg;
    logic [8:0]         aw2_reg;
    logic [8:0]         ah2_reg;
    logic signed [30:0] cx2_reg;
    logic signed [30:0] cy2_reg;
    logic [31:0]        score2_prod;

    // stage 3: sizes in network pixels, scaled centers
    logic [15:0]        score3_reg;
    logic [26:0]        szw3_reg;
    logic [26:0]        szh3_reg;
    logic signed [47:0] cx3_reg;
    logic signed [47:0] cy3_reg;
    logic [40:0]        szw3_prod;
    logic [40:0]        szh3_prod;

    // stage 4: scaled sizes
    logic [15:0]        score4_reg;
    logic [42:0]        w4_reg;
    logic [42:0]        h4_reg;
    logic signed [47:0] cx4_reg;
    logic signed [47:0] cy4_reg;

    // stage 5: edge numerators and extents
    logic [15:0]        score5_reg;
    logic signed [49:0] numx5_reg;
    logic signed [49:0] numy5_reg;
    logic [14:0]        wid5_reg;
    logic [14:0]        hei5_reg;

    // stage 6: output register
    abhd_pkg::box_t     box_reg;

    // configuration write port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_threshold_reg <= abhd_pkg::SCORE_THRESHOLD_RESET;
            pad_left_reg        <= abhd_pkg::PAD_RESET;
            pad_top_reg         <= abhd_pkg::PAD_RESET;
            scale_x_reg         <= abhd_pkg::SCALE_RESET;
            scale_y_reg         <= abhd_pkg::SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                abhd_pkg::REG_SCORE_THRESHOLD: score_threshold_reg <= cfg_data;
                abhd_pkg::REG_PAD_LEFT:        pad_left_reg        <= cfg_data[8:0];
                abhd_pkg::REG_PAD_TOP:         pad_top_reg         <= cfg_data[8:0];
                abhd_pkg::REG_SCALE_X:         scale_x_reg         <= cfg_data;
                abhd_pkg::REG_SCALE_Y:         scale_y_reg         <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // ready chain: a stage loads when it is empty or its content moves on
    assign rdy[6] = !v_reg[6] || box_ready;
    assign rdy[5] = !v_reg[5] || rdy[6];
    assign rdy[4] = !v_reg[4] || rdy[5];
    assign rdy[3] = !v_reg[3] || rdy[4];
    assign rdy[2] = !v_reg[2] || rdy[3];
    assign rdy[1] = !v_reg[1] || rdy[2];

    assign cell_ready = rdy[1];

    // valid bits, with drops at entry and at the score check
    always_comb
    begin
        v_next[1] = cell_valid && cell_data.level != 2'd3 && cell_data.anchor_slot != 2'd3;
        v_next[2] = v_reg[1];
        v_next[3] = v_reg[2] && obj_ok2_reg && (score2_reg >= score_threshold_reg);
        v_next[4] = v_reg[3];
        v_next[5] = v_reg[4];
        v_next[6] = v_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= (v_reg & ~rdy) | (v_next & rdy);
        end
    end

    // stage 1: sigmoid tables
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            level1_reg <= cell_data.level;
            slot1_reg  <= cell_data.anchor_slot;
            col1_reg   <= cell_data.grid_col;
            row1_reg   <= cell_data.grid_row;
            sx1_reg    <= abhd_pkg::sigmoid_q16(cell_data.logit_x);
            sy1_reg    <= abhd_pkg::sigmoid_q16(cell_data.logit_y);
            sw1_reg    <= abhd_pkg::sigmoid_q16(cell_data.logit_w);
            sh1_reg    <= abhd_pkg::sigmoid_q16(cell_data.logit_h);
            sobj1_reg  <= abhd_pkg::sigmoid_q16(cell_data.logit_obj);
            scls1_reg  <= abhd_pkg::sigmoid_q16(cell_data.logit_cls);
        end
    end

    // stage 2: score product, size squares, centers
    assign score2_prod = sobj1_reg * scls1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            score2_reg  <= score2_prod[31:16];
            obj_ok2_reg <= sobj1_reg > score_threshold_reg;
            sqw2_reg    <= sw1_reg * sw1_reg;
            sqh2_reg    <= sh1_reg * sh1_reg;
            aw2_reg     <= abhd_pkg::anchor_size(level1_reg, slot1_reg, 1'b0);
            ah2_reg     <= abhd_pkg::anchor_size(level1_reg, slot1_reg, 1'b1);
            cx2_reg     <= abhd_pkg::center_q16(sx1_reg, col1_reg, level1_reg, pad_left_reg);
            cy2_reg     <= abhd_pkg::center_q16(sy1_reg, row1_reg, level1_reg, pad_top_reg);
        end
    end

    // stage 3: anchor multiply, center scale
    assign szw3_prod = sqw2_reg * aw2_reg;
    assign szh3_prod = sqh2_reg * ah2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            score3_reg <= score2_reg;
            szw3_reg   <= szw3_prod[40:14];
            szh3_reg   <= szh3_prod[40:14];
            cx3_reg    <= cx2_reg * $signed({1'b0, scale_x_reg});
            cy3_reg    <= cy2_reg * $signed({1'b0, scale_y_reg});
        end
    end

    // stage 4: size scale
    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            score4_reg <= score3_reg;
            w4_reg     <= szw3_reg * scale_x_reg;
            h4_reg     <= szh3_reg * scale_y_reg;
            cx4_reg    <= cx3_reg;
            cy4_reg    <= cy3_reg;
        end
    end

    // stage 5: twice the center minus the size, extents
    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            score5_reg <= score4_reg;
            numx5_reg  <= (50'(cx4_reg) <<< 1) - $signed({7'b0, w4_reg});
            numy5_reg  <= (50'(cy4_reg) <<< 1) - $signed({7'b0, h4_reg});
            wid5_reg   <= abhd_pkg::extent_px(w4_reg);
            hei5_reg   <= abhd_pkg::extent_px(h4_reg);
        end
    end

    // stage 6: edge truncation and saturation into the output register
    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            box_reg.box_left   <= abhd_pkg::edge_px(numx5_reg);
            box_reg.box_top    <= abhd_pkg::edge_px(numy5_reg);
            box_reg.box_width  <= wid5_reg;
            box_reg.box_height <= hei5_reg;
            box_reg.score      <= score5_reg;
        end
    end

    assign box_valid = v_reg[6];
    assign box       = box_reg;

    // a cell with an unused level never occupies stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && cell_ready && cell_data.level == 2'd3) |=> !v_reg[1])
        else $error("cell with level three entered the pipeline");

    // with the output empty, every stage is free to take a cell
    assert property (@(posedge clk) disable iff (!rst_n)
        !box_valid |-> cell_ready)
        else $error("cell side blocked while output register is empty");

    // product of two probabilities below one stays below full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        box_valid |-> box.score != abhd_pkg::SIG_MAX)
        else $error("score reached full scale");

    // under a stall on a full output register, stage five keeps its content
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[5] && v_reg[6] && !box_ready) |=> (v_reg[5] && $stable(numx5_reg)))
        else $error("stage five content lost under a stall");

endmodule
